[src/hsvrgb_pkg.sv]
// Shared constants, payload types and sector codes for the HSV to RGB converter.
// Depends on nothing; every other file of the block imports it.
package hsvrgb_pkg;

	localparam int CH_W       = 8;
	localparam int HUE_W      = 16;
	localparam int HC_W       = 15;
	localparam int FRAC_W     = 12;
	localparam int HUE_FULL   = 23040;
	localparam int HUE_SECTOR = 3840;
	localparam int CH_MAX     = 255;
	localparam int N_SECTOR   = 6;

	// q and t numerators: v * (D - s*F), D = 255 * 3840
	localparam int QT_DEN     = CH_MAX * HUE_SECTOR;
	localparam int NUM_W      = 20;
	localparam int PROD_W     = CH_W + NUM_W;
	localparam int QT_PRE     = 8;
	localparam int QT_DIV     = QT_DEN / (1 << QT_PRE);
	localparam int QT_RSH     = 32;
	localparam int unsigned QT_RECIP = 32'((64'd1 << QT_RSH) / QT_DIV);

	// p numerator: v * (255 - s)
	localparam int PZ_W       = 2 * CH_W;
	localparam int P_PRE      = 0;
	localparam int P_RSH      = 24;
	localparam int unsigned P_RECIP = 32'((64'd1 << P_RSH) / CH_MAX);

	localparam int S_DATA_W   = HUE_W + 2 * CH_W;
	localparam int M_DATA_W   = 3 * CH_W;

	typedef enum logic [2:0] {
		SEC_RED     = 3'd0,
		SEC_YELLOW  = 3'd1,
		SEC_GREEN   = 3'd2,
		SEC_CYAN    = 3'd3,
		SEC_BLUE    = 3'd4,
		SEC_MAGENTA = 3'd5
	} sector_t;

	typedef struct packed {
		logic [CH_W-1:0]   sat;
		logic [CH_W-1:0]   bri;
		sector_t           sector;
		logic [FRAC_W-1:0] frac;
	} front_t;

	typedef struct packed {
		sector_t         sector;
		logic [CH_W-1:0] bri;
	} side_t;

endpackage

[src/hsvrgb_front.sv]
// Stage 1: hue wrap, sector index and in-sector fraction.
// Depends on hsvrgb_pkg.
module hsvrgb_front (
	input  logic                           clk,
	input  logic                           en,
	input  logic [hsvrgb_pkg::HUE_W-1:0]   hue,
	input  logic [hsvrgb_pkg::CH_W-1:0]    saturation,
	input  logic [hsvrgb_pkg::CH_W-1:0]    brightness,
	output hsvrgb_pkg::front_t             pix_s1
);
	import hsvrgb_pkg::*;

	logic [HC_W-1:0] hc;
	logic [2:0]      cnt;
	logic [HC_W-1:0] base;

	// wrap: a full turn or more reads as zero
	assign hc = (hue >= HUE_W'(HUE_FULL)) ? '0 : hue[HC_W-1:0];

	always_comb begin
		cnt = '0;
		for (int k = 1; k < N_SECTOR; k++) begin
			if (hc >= HC_W'(k * HUE_SECTOR)) begin
				cnt = 3'(k);
			end
		end
	end

	assign base = HC_W'(cnt) * HC_W'(HUE_SECTOR);

	always_ff @(posedge clk) begin
		if (en) begin
			pix_s1.sat    <= saturation;
			pix_s1.bri    <= brightness;
			pix_s1.sector <= sector_t'(cnt);
			pix_s1.frac   <= FRAC_W'(hc - base);
		end
	end

endmodule

[src/hsvrgb_prod.sv]
// Stages 2 and 3: numerators of p, q and t; each path has at most one multiply per stage.
// Depends on hsvrgb_pkg.
module hsvrgb_prod (
	input  logic                            clk,
	input  logic                            en_s2,
	input  logic                            en_s3,
	input  hsvrgb_pkg::front_t              pix_s1,
	output logic [hsvrgb_pkg::PROD_W-1:0]   xq_s3,
	output logic [hsvrgb_pkg::PROD_W-1:0]   xt_s3,
	output logic [hsvrgb_pkg::PZ_W-1:0]     pz_s3
);
	import hsvrgb_pkg::*;

	logic [FRAC_W-1:0] comp;
	logic [NUM_W-1:0]  sf;
	logic [NUM_W-1:0]  sc;
	logic [NUM_W-1:0]  nq_s2;
	logic [NUM_W-1:0]  nt_s2;
	logic [PZ_W-1:0]   pz_s2;
	logic [CH_W-1:0]   bri_s2;

	assign comp = FRAC_W'(HUE_SECTOR) - pix_s1.frac;
	assign sf   = NUM_W'(pix_s1.sat) * NUM_W'(pix_s1.frac);
	assign sc   = NUM_W'(pix_s1.sat) * NUM_W'(comp);

	always_ff @(posedge clk) begin
		if (en_s2) begin
			nq_s2  <= NUM_W'(QT_DEN) - sf;
			nt_s2  <= NUM_W'(QT_DEN) - sc;
			pz_s2  <= PZ_W'(pix_s1.bri) * PZ_W'(CH_W'(CH_MAX) - pix_s1.sat);
			bri_s2 <= pix_s1.bri;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			xq_s3 <= PROD_W'(bri_s2) * PROD_W'(nq_s2);
			xt_s3 <= PROD_W'(bri_s2) * PROD_W'(nt_s2);
			pz_s3 <= pz_s2;
		end
	end

endmodule

[src/hsvrgb_cdiv.sv]
// Stages 4 and 5: truncating division by a constant, reciprocal estimate then
// one compare-and-increment fix. Depends on hsvrgb_pkg.
module hsvrgb_cdiv #(
	parameter int          IN_W    = hsvrgb_pkg::PROD_W,
	parameter int          PRE_SH  = hsvrgb_pkg::QT_PRE,
	parameter int unsigned DIVISOR = hsvrgb_pkg::QT_DIV,
	parameter int unsigned RECIP   = hsvrgb_pkg::QT_RECIP,
	parameter int          RSH     = hsvrgb_pkg::QT_RSH
) (
	input  logic                          clk,
	input  logic                          en_s4,
	input  logic                          en_s5,
	input  logic [IN_W-1:0]               num,
	output logic [hsvrgb_pkg::CH_W-1:0]   quo_s5
);
	import hsvrgb_pkg::*;

	localparam int YW  = IN_W - PRE_SH;
	localparam int RW  = $clog2(RECIP + 1);
	localparam int PW  = YW + RW;
	localparam int YW1 = YW + 1;

	logic [YW-1:0]   y;
	logic [PW-1:0]   prod;
	logic [YW-1:0]   y_s4;
	logic [CH_W-1:0] est_s4;
	logic [YW-1:0]   back;
	logic [YW-1:0]   rem;

	// the low PRE_SH bits cannot change the quotient
	assign y    = num[IN_W-1:PRE_SH];
	assign prod = PW'(y) * PW'(RECIP);

	always_ff @(posedge clk) begin
		if (en_s4) begin
			y_s4   <= y;
			est_s4 <= prod[RSH +: CH_W];
		end
	end

	// estimate is exact or one short
	assign back = YW'(est_s4) * YW'(DIVISOR);
	assign rem  = y_s4 - back;

	always_ff @(posedge clk) begin
		if (en_s5) begin
			quo_s5 <= est_s4 + CH_W'(rem >= YW'(DIVISOR));
		end
	end

`ifndef NO_ASSERTIONS
	a_rem_bound: assert property (@(posedge clk)
		en_s5 |-> ({1'b0, rem} < YW1'(2 * DIVISOR)))
		else $error("divider estimate off by more than one");
`endif

endmodule

[src/hsv_to_rgb_converter_unit.sv]
// Top level of the HSV to RGB converter: handshake, valid/ready chain and the
// sector routing output register. Depends on hsvrgb_pkg, hsvrgb_front,
// hsvrgb_prod and hsvrgb_cdiv.
//
// Channel   Direction  Payload (low bit first)                 Transaction
// s_axis    in         hue[15:0] sat[23:16] bri[31:24]         s_tvalid && s_tready
// m_axis    out        red[7:0] green[15:8] blue[23:16]        m_tvalid && m_tready
//
// An accepted input transaction passes through the stage registers s1 to s6 in order,
// s6 being the output register; throughput is one pixel per cycle while m_tready stays
// high, since every stage can reload in each cycle.
// Each stage carries its own valid bit, and a stage loads whenever it is empty or
// the stage after it moves, so bubbles are squeezed out under back-pressure.
// A stall on m_tready holds each full stage with no empty stage after it; nothing is
// dropped or repeated. arst_n clears only the valid bits, not the payload registers.
module hsv_to_rgb_converter_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [hsvrgb_pkg::S_DATA_W-1:0]     s_tdata,  // hue, saturation, brightness
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [hsvrgb_pkg::M_DATA_W-1:0]     m_tdata   // red, green, blue
);
	import hsvrgb_pkg::*;

	// Stage valid bits
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	// Stage ready: a stage may load when empty or when its content moves on
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6;
	// Load enables: ready and something to load
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6;

	front_t pix_s1;
	side_t  side_s2, side_s3, side_s4, side_s5;

	logic [PROD_W-1:0] xq_s3, xt_s3;
	logic [PZ_W-1:0]   pz_s3;
	logic [CH_W-1:0]   q_s5, t_s5, p_s5;
	logic [CH_W-1:0]   red_s6, green_s6, blue_s6;

	assign rdy_s6 = !vld_s6 || m_tready;
	assign rdy_s5 = !vld_s5 || rdy_s6;
	assign rdy_s4 = !vld_s4 || rdy_s5;
	assign rdy_s3 = !vld_s3 || rdy_s4;
	assign rdy_s2 = !vld_s2 || rdy_s3;
	assign rdy_s1 = !vld_s1 || rdy_s2;

	assign en_s1 = rdy_s1 && s_tvalid;
	assign en_s2 = rdy_s2 && vld_s1;
	assign en_s3 = rdy_s3 && vld_s2;
	assign en_s4 = rdy_s4 && vld_s3;
	assign en_s5 = rdy_s5 && vld_s4;
	assign en_s6 = rdy_s6 && vld_s5;

	assign s_tready = rdy_s1;
	assign m_tvalid = vld_s6;
	assign m_tdata  = {blue_s6, green_s6, red_s6};

	// Advance valid bits; a stage that moves on without a refill goes empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= s_tvalid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
			if (rdy_s4) vld_s4 <= vld_s3;
			if (rdy_s5) vld_s5 <= vld_s4;
			if (rdy_s6) vld_s6 <= vld_s5;
		end
	end

	// Stage 1: wrap hue, split into sector and fraction
	hsvrgb_front u_front (
		.clk        (clk),
		.en         (en_s1),
		.hue        (s_tdata[HUE_W-1:0]),
		.saturation (s_tdata[HUE_W +: CH_W]),
		.brightness (s_tdata[HUE_W+CH_W +: CH_W]),
		.pix_s1     (pix_s1)
	);

	// Stages 2-3: numerators
	hsvrgb_prod u_prod (
		.clk    (clk),
		.en_s2  (en_s2),
		.en_s3  (en_s3),
		.pix_s1 (pix_s1),
		.xq_s3  (xq_s3),
		.xt_s3  (xt_s3),
		.pz_s3  (pz_s3)
	);

	// Stages 4-5: divide by 255*3840 for q and t, by 255 for p
	hsvrgb_cdiv #(
		.IN_W    (PROD_W),
		.PRE_SH  (QT_PRE),
		.DIVISOR (QT_DIV),
		.RECIP   (QT_RECIP),
		.RSH     (QT_RSH)
	) u_div_q (
		.clk    (clk),
		.en_s4  (en_s4),
		.en_s5  (en_s5),
		.num    (xq_s3),
		.quo_s5 (q_s5)
	);

	hsvrgb_cdiv #(
		.IN_W    (PROD_W),
		.PRE_SH  (QT_PRE),
		.DIVISOR (QT_DIV),
		.RECIP   (QT_RECIP),
		.RSH     (QT_RSH)
	) u_div_t (
		.clk    (clk),
		.en_s4  (en_s4),
		.en_s5  (en_s5),
		.num    (xt_s3),
		.quo_s5 (t_s5)
	);

	hsvrgb_cdiv #(
		.IN_W    (PZ_W),
		.PRE_SH  (P_PRE),
		.DIVISOR (CH_MAX),
		.RECIP   (P_RECIP),
		.RSH     (P_RSH)
	) u_div_p (
		.clk    (clk),
		.en_s4  (en_s4),
		.en_s5  (en_s5),
		.num    (pz_s3),
		.quo_s5 (p_s5)
	);

	// Carry sector and value alongside the arithmetic
	always_ff @(posedge clk) begin
		if (en_s2) begin
			side_s2.sector <= pix_s1.sector;
			side_s2.bri    <= pix_s1.bri;
		end
		if (en_s3) side_s3 <= side_s2;
		if (en_s4) side_s4 <= side_s3;
		if (en_s5) side_s5 <= side_s4;
	end

	// Stage 6: route v, p, q, t by sector. Zero saturation needs no special
	// case: p, q and t all come out equal to v then.
	always_ff @(posedge clk) begin
		if (en_s6) begin
			case (side_s5.sector)
				SEC_RED: begin
					red_s6 <= side_s5.bri; green_s6 <= t_s5; blue_s6 <= p_s5;
				end
				SEC_YELLOW: begin
					red_s6 <= q_s5; green_s6 <= side_s5.bri; blue_s6 <= p_s5;
				end
				SEC_GREEN: begin
					red_s6 <= p_s5; green_s6 <= side_s5.bri; blue_s6 <= t_s5;
				end
				SEC_CYAN: begin
					red_s6 <= p_s5; green_s6 <= q_s5; blue_s6 <= side_s5.bri;
				end
				SEC_BLUE: begin
					red_s6 <= t_s5; green_s6 <= p_s5; blue_s6 <= side_s5.bri;
				end
				default: begin
					red_s6 <= side_s5.bri; green_s6 <= p_s5; blue_s6 <= q_s5;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	// A full pipeline under a stalled output must refuse input
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && vld_s2 && vld_s3 && vld_s4 && vld_s5 && vld_s6 && !m_tready)
		|-> !s_tready)
		else $error("input taken while pipeline full and stalled");

	// p is the smallest channel
	a_p_min: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s5 |-> (p_s5 <= q_s5 && p_s5 <= t_s5))
		else $error("p exceeds q or t");

	// q and t never exceed the value
	a_v_max: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s5 |-> (q_s5 <= side_s5.bri && t_s5 <= side_s5.bri))
		else $error("q or t exceeds value");
`endif

endmodule

[bench/hsv_to_rgb_converter_unit_test.sv]
// Self-checking bench for hsv_to_rgb_converter_unit: a pixel ledger predicts RGB from
// every accepted HSV transaction and checks results in order. Needs hsvrgb_pkg and the
// converter RTL only.
`timescale 1ns / 100ps

module hsv_to_rgb_converter_unit_test;
	import hsvrgb_pkg::*;

	// Hue geometry and fixed-point denominator, kept apart from the RTL's own constants
	localparam int unsigned FULL_TURN   = 23040;
	localparam int unsigned SECTOR_SPAN = 3840;
	localparam int unsigned CH_FULL     = 255;
	localparam int unsigned FRAC_DEN    = CH_FULL * SECTOR_SPAN;

	// Input word, hue in the low bits
	typedef struct packed {
		logic [7:0]  bri;
		logic [7:0]  sat;
		logic [15:0] hue;
	} hsv_pixel_t;

	// Output word, red in the low bits
	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} rgb_pixel_t;

	class rgb_ledger;
		rgb_pixel_t pending_rgb[$];
		int faults;

		function rgb_pixel_t convert_hsv(hsv_pixel_t px);
			int unsigned h, s, v, frac, p, q, t;
			sector_t sec;
			rgb_pixel_t rgb;
			h = px.hue;
			s = px.sat;
			v = px.bri;
			// grey: every channel follows brightness, hue is ignored
			if (s == 0) begin
				rgb.red   = v[7:0];
				rgb.green = v[7:0];
				rgb.blue  = v[7:0];
				return rgb;
			end
			// a full turn or beyond folds back to red
			if (h >= FULL_TURN)
				h = 0;
			sec  = sector_t'(h / SECTOR_SPAN);
			frac = h % SECTOR_SPAN;
			p = v * (CH_FULL - s) / CH_FULL;
			q = v * (FRAC_DEN - s * frac) / FRAC_DEN;
			t = v * (FRAC_DEN - s * (SECTOR_SPAN - frac)) / FRAC_DEN;
			case (sec)
				SEC_RED: begin
					rgb.red = v[7:0]; rgb.green = t[7:0]; rgb.blue = p[7:0];
				end
				SEC_YELLOW: begin
					rgb.red = q[7:0]; rgb.green = v[7:0]; rgb.blue = p[7:0];
				end
				SEC_GREEN: begin
					rgb.red = p[7:0]; rgb.green = v[7:0]; rgb.blue = t[7:0];
				end
				SEC_CYAN: begin
					rgb.red = p[7:0]; rgb.green = q[7:0]; rgb.blue = v[7:0];
				end
				SEC_BLUE: begin
					rgb.red = t[7:0]; rgb.green = p[7:0]; rgb.blue = v[7:0];
				end
				default: begin
					rgb.red = v[7:0]; rgb.green = p[7:0]; rgb.blue = q[7:0];
				end
			endcase
			return rgb;
		endfunction

		function void note_pixel(hsv_pixel_t px);
			pending_rgb.push_back(convert_hsv(px));
		endfunction

		function void log_fault(string msg);
			faults++;
			if (faults <= 10)
				$display("[%0t] %s", $time, msg);
		endfunction

		function void check_pixel(rgb_pixel_t got);
			rgb_pixel_t want;
			if (pending_rgb.size() == 0) begin
				log_fault($sformatf("unexpected result r=%0d g=%0d b=%0d",
					got.red, got.green, got.blue));
				return;
			end
			want = pending_rgb.pop_front();
			if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue)
				log_fault($sformatf("rgb mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
					want.red, want.green, want.blue, got.red, got.green, got.blue));
		endfunction

		function int outstanding();
			return pending_rgb.size();
		endfunction

		// leftover expectations count as failures too
		function int failures();
			return faults + pending_rgb.size();
		endfunction
	endclass

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASES = 4;
	localparam int PHASE_PIXELS = 150;
	// per phase: none, sender only, receiver only, both
	localparam int SEND_IDLE [PHASES] = '{0, 51, 0, 37};
	localparam int RECV_STALL [PHASES] = '{0, 0, 51, 37};

	// corners: {brightness, saturation, hue}
	localparam logic [31:0] CORNER_PIXELS [21] = '{
		{8'd255, 8'd255, 16'd0},      // pure red, hue zero
		{8'd255, 8'd255, 16'd3839},   // last hue of the red sector
		{8'd255, 8'd255, 16'd3840},
		{8'd200, 8'd128, 16'd7679},
		{8'd255, 8'd255, 16'd7680},
		{8'd255, 8'd1,   16'd11519},  // faintest saturation
		{8'd255, 8'd255, 16'd11520},
		{8'd1,   8'd255, 16'd15359},
		{8'd255, 8'd255, 16'd15360},
		{8'd133, 8'd77,  16'd19199},
		{8'd255, 8'd255, 16'd19200},
		{8'd255, 8'd255, 16'd21000},
		{8'd255, 8'd255, 16'd23039},  // just short of a full turn
		{8'd180, 8'd200, 16'd23040},  // full turn folds to zero
		{8'd255, 8'd255, 16'd65535},  // largest hue code
		{8'd200, 8'd0,   16'd1920},   // grey
		{8'd255, 8'd0,   16'd40000},  // grey with out-of-range hue
		{8'd0,   8'd0,   16'd0},
		{8'd0,   8'd255, 16'd9600},   // black with full saturation
		{8'd1,   8'd1,   16'd13440},
		{8'd254, 8'd254, 16'd5000}
	};

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_left = 0;
	int cycles = 0;

	rgb_ledger ledger = new;

	hsv_to_rgb_converter_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // hue, saturation, brightness
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)    // red, green, blue
	);

	always #6 clk = ~clk;

	// Watchdog: a hung handshake ends the run here
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	// Receiver: check each result transaction, then pick next cycle's ready.
	// A pending hold-off forces ready low and is counted down here.
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				ledger.check_pixel(rgb_pixel_t'(m_tdata));
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Offer one pixel, idling first at the current rate; return at its transaction.
	// Valid stays high when the next pixel follows straight away.
	task automatic send_pixel(input hsv_pixel_t px);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= px;
		do @(posedge clk); while (!s_tready);
		ledger.note_pixel(px);
	endtask

	// Drop valid and hold until every predicted pixel has come back
	task automatic drain();
		s_tvalid <= 1'b0;
		while (ledger.outstanding() != 0)
			@(posedge clk);
	endtask

	// Mostly in-range hues, with sector edges, wrap-around codes and the
	// saturation/brightness extremes mixed in
	function automatic hsv_pixel_t random_pixel();
		hsv_pixel_t px;
		case ($urandom_range(9))
			0: px.hue = 16'($urandom);
			1: px.hue = 16'(SECTOR_SPAN * $urandom_range(1, 6) + $urandom_range(2) - 1);
			default: px.hue = 16'($urandom_range(FULL_TURN - 1));
		endcase
		case ($urandom_range(7))
			0: px.sat = 8'd0;
			1: px.sat = 8'd255;
			default: px.sat = 8'($urandom);
		endcase
		case ($urandom_range(11))
			0: px.bri = 8'd0;
			1: px.bri = 8'd255;
			default: px.bri = 8'($urandom);
		endcase
		return px;
	endfunction

	initial begin
		int ph;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed corners, back to back
		foreach (CORNER_PIXELS[i])
			send_pixel(hsv_pixel_t'(CORNER_PIXELS[i]));
		drain();

		for (ph = 0; ph < PHASES; ph++) begin
			send_idle_pct  = SEND_IDLE[ph];
			recv_stall_pct = RECV_STALL[ph];
			repeat (PHASE_PIXELS)
				send_pixel(random_pixel());
			drain();
			// Back-pressure burst: receiver holds off while the sender keeps
			// offering, so the pipeline fills and input ready drops
			if (ph == 0) begin
				hold_left = 200;
				repeat (40)
					send_pixel(random_pixel());
				drain();
			end
		end

		// Let the pipeline run dry and catch any stray result
		repeat (20) @(posedge clk);
		if (ledger.failures() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
